// ===== rtl/ott_pkg.sv =====
// Shared types and constants of the ordered tile table.
`timescale 1ns / 1ps

package ott_pkg;

    localparam int TABLE_DEPTH_DEF = 256;

    // Accepted column and row range for an add
    localparam logic signed [7:0] XY_MAX = 8'sd123;
    localparam logic signed [7:0] XY_MIN = -8'sd124;

    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_READ   = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        ST_INSERTED  = 4'd0,
        ST_REPLACED  = 4'd1,
        ST_UNCHANGED = 4'd2,
        ST_RANGE     = 4'd3,
        ST_FULL      = 4'd4,
        ST_REMOVED   = 4'd5,
        ST_NOT_FOUND = 4'd6,
        ST_READ_OK   = 4'd7,
        ST_READ_PAST = 4'd8
    } t_status;

endpackage

// ===== rtl/ordered_tile_table.sv =====
// Ordered tile table: sequencer, table memory and result register.
`timescale 1ns / 1ps

// Packed, ordered table of map tiles keyed by (layer, x, y), held in a single
// TABLE_DEPTH x 32 memory with one write and one registered read port. A small
// sequencer walks the memory one entry per cycle: a key scan, a shift down
// that closes the gap of a removed or replaced tile, an ordering scan that
// finds the insert position, and a shift up that opens a slot. A read needs
// none of the passes, a remove at most the key scan and the shift down, and
// an add up to all four; the memory port is used once per cycle by every
// pass. The input side is ready only while the sequencer is idle; one
// finished result waits in the output register so the next word can be
// taken before it is drained. The store needs no clearing pass after reset:
// only entries below the fill count are ever used.
module ordered_tile_table
    import ott_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input word
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: entry_layer[7:0], entry_x[15:8], entry_y[23:16], entry_id[31:24],
    //        read_position[39:32]
    input  logic [39:0] s_axis_tdata,
    // tuser: kind[1:0]
    input  logic [1:0]  s_axis_tuser,
    // result word
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: status[3:0], entry_count[12:4], out_layer[20:13], out_x[28:21],
    //        out_y[36:29], out_id[44:37], zero[47:45]
    output logic [47:0] m_axis_tdata
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);  // count and index width
    localparam int AW = $clog2(TABLE_DEPTH);      // memory address width

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,   // key scan
        S_DEL,    // shift down over the removed slot
        S_POS,    // ordering scan for the insert position
        S_INS,    // shift up to open the slot
        S_WR,     // write the new tile
        S_RD,     // read port latency for a read op
        S_DONE
    } t_state;

    // ---------------------------------------------------------------
    // Table memory: registered read
    // ---------------------------------------------------------------
    logic [31:0]   r_mem [TABLE_DEPTH];
    logic [31:0]   r_rdata;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic [AW-1:0] rd_addr;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        // write-first: a read of the slot being written returns the new word
        if (mem_we && (mem_waddr == rd_addr)) begin
            r_rdata <= mem_wdata;
        end else begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // ---------------------------------------------------------------
    // Sequencer registers
    // ---------------------------------------------------------------
    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;      // index of the entry in r_rdata (idx+1 in S_DEL)
    logic [CW-1:0] r_pos, n_pos;      // insert position
    logic [1:0]    r_kind, n_kind;
    logic [31:0]   r_key, n_key;      // layer, x, y, id from high to low
    logic [31:0]   r_entry, n_entry;  // entry returned by a read
    t_status       r_status, n_status;
    logic          r_in_layer, n_in_layer;
    logic          r_in_group, n_in_group;
    logic          r_out_valid, n_out_valid;
    logic [47:0]   r_out_data, n_out_data;

    // Current entry and key fields
    logic signed [7:0] e_layer, e_x, e_y;
    logic        [7:0] e_id;
    logic signed [7:0] k_layer, k_x, k_y;
    logic        [7:0] k_id;
    logic signed [7:0] in_x, in_y;
    logic              lay_eq, id_eq, key_gt, scan_end;
    logic [CW-1:0]     idx_p1, idx_p2, idx_m1, cnt_m1;
    logic [31:0]       rpos_ext, cnt_ext;

    assign e_layer  = r_rdata[31:24];
    assign e_x      = r_rdata[23:16];
    assign e_y      = r_rdata[15:8];
    assign e_id     = r_rdata[7:0];
    assign k_layer  = r_key[31:24];
    assign k_x      = r_key[23:16];
    assign k_y      = r_key[15:8];
    assign k_id     = r_key[7:0];
    assign in_x     = s_axis_tdata[15:8];
    assign in_y     = s_axis_tdata[23:16];

    assign lay_eq   = (e_layer == k_layer);
    assign id_eq    = (e_id == k_id);
    assign key_gt   = (k_x > e_x) || ((k_x == e_x) && (k_y > e_y));
    assign scan_end = (r_idx == r_count);

    assign idx_p1   = CW'(r_idx + 1'b1);
    assign idx_p2   = CW'(r_idx + 2'd2);
    assign idx_m1   = CW'(r_idx - 1'b1);
    assign cnt_m1   = CW'(r_count - 1'b1);
    assign rpos_ext = 32'(s_axis_tdata[39:32]);
    assign cnt_ext  = 32'(r_count);

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_kind      = r_kind;
        n_key       = r_key;
        n_entry     = r_entry;
        n_status    = r_status;
        n_in_layer  = r_in_layer;
        n_in_group  = r_in_group;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = r_key;
        rd_addr     = '0;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_key   = {s_axis_tdata[7:0], s_axis_tdata[15:8],
                               s_axis_tdata[23:16], s_axis_tdata[31:24]};
                    n_kind  = s_axis_tuser;
                    n_entry = '0;
                    n_idx   = '0;     // read of entry 0 primes the key scan
                    unique case (s_axis_tuser)
                        KIND_ADD: begin
                            if (in_x > XY_MAX || in_x < XY_MIN ||
                                in_y > XY_MAX || in_y < XY_MIN) begin
                                n_status = ST_RANGE;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_FIND;
                            end
                        end
                        KIND_REMOVE: begin
                            n_state = S_FIND;
                        end
                        KIND_READ: begin
                            if (rpos_ext < cnt_ext) begin
                                rd_addr = rpos_ext[AW-1:0];
                                n_state = S_RD;
                            end else begin
                                n_status = ST_READ_PAST;
                                n_state  = S_DONE;
                            end
                        end
                        default: begin
                            n_status = ST_UNCHANGED;
                            n_state  = S_DONE;
                        end
                    endcase
                end
            end

            S_FIND: begin
                if (scan_end) begin
                    if (r_kind == KIND_REMOVE) begin
                        n_status = ST_NOT_FOUND;
                        n_state  = S_DONE;
                    end else if (r_count == CW'(TABLE_DEPTH)) begin
                        n_status = ST_FULL;
                        n_state  = S_DONE;
                    end else begin
                        n_status   = ST_INSERTED;
                        n_idx      = '0;
                        n_in_layer = 1'b0;
                        n_in_group = 1'b0;
                        n_state    = S_POS;
                    end
                end else if (r_rdata[31:8] == r_key[31:8]) begin
                    n_status = (r_kind == KIND_REMOVE) ? ST_REMOVED : ST_REPLACED;
                    if ((r_kind == KIND_ADD) && id_eq) begin
                        n_status = ST_UNCHANGED;
                        n_state  = S_DONE;
                    end else if (idx_p1 == r_count) begin
                        // hit is the last entry: nothing to shift
                        n_count    = cnt_m1;
                        n_idx      = '0;
                        n_in_layer = 1'b0;
                        n_in_group = 1'b0;
                        n_state    = (r_kind == KIND_ADD) ? S_POS : S_DONE;
                    end else begin
                        rd_addr = idx_p1[AW-1:0];
                        n_state = S_DEL;
                    end
                end else begin
                    rd_addr = idx_p1[AW-1:0];
                    n_idx   = idx_p1;
                end
            end

            S_DEL: begin
                // r_rdata holds entry idx+1, moved down to idx
                mem_we    = 1'b1;
                mem_waddr = r_idx[AW-1:0];
                mem_wdata = r_rdata;
                if (idx_p2 == r_count) begin
                    n_count    = cnt_m1;
                    n_idx      = '0;
                    n_in_layer = 1'b0;
                    n_in_group = 1'b0;
                    n_state    = (r_kind == KIND_ADD) ? S_POS : S_DONE;
                end else begin
                    rd_addr = idx_p2[AW-1:0];
                    n_idx   = idx_p1;
                end
            end

            S_POS: begin
                logic found;
                found = 1'b0;
                if (scan_end) begin
                    found = 1'b1;
                end else if (r_in_group) begin
                    found = !lay_eq || !id_eq || key_gt;
                end else if (lay_eq) begin
                    n_in_layer = 1'b1;
                    if (id_eq) begin
                        n_in_group = 1'b1;
                        found      = key_gt;
                    end
                end else if (r_in_layer) begin
                    found = 1'b1;      // walked past the end of the layer
                end else if (k_layer < e_layer) begin
                    found = 1'b1;
                end

                if (found) begin
                    n_pos = r_idx;
                    if (scan_end) begin
                        n_state = S_WR;
                    end else begin
                        rd_addr = cnt_m1[AW-1:0];
                        n_idx   = cnt_m1;
                        n_state = S_INS;
                    end
                end else begin
                    rd_addr = idx_p1[AW-1:0];
                    n_idx   = idx_p1;
                end
            end

            S_INS: begin
                // r_rdata holds entry idx, moved up to idx+1
                mem_we    = 1'b1;
                mem_waddr = idx_p1[AW-1:0];
                mem_wdata = r_rdata;
                rd_addr   = idx_m1[AW-1:0];
                if (r_idx == r_pos) begin
                    n_state = S_WR;
                end else begin
                    n_idx = idx_m1;
                end
            end

            S_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos[AW-1:0];
                mem_wdata = r_key;
                n_count   = CW'(r_count + 1'b1);
                n_state   = S_DONE;
            end

            S_RD: begin
                n_entry  = r_rdata;
                n_status = ST_READ_OK;
                n_state  = S_DONE;
            end

            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {3'b000, r_entry[7:0], r_entry[15:8],
                                   r_entry[23:16], r_entry[31:24],
                                   cnt_ext[8:0], r_status};
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_in_layer  <= 1'b0;
            r_in_group  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_in_layer  <= n_in_layer;
            r_in_group  <= n_in_group;
        end
        r_idx      <= n_idx;
        r_pos      <= n_pos;
        r_kind     <= n_kind;
        r_key      <= n_key;
        r_entry    <= n_entry;
        r_status   <= n_status;
        r_out_data <= n_out_data;
    end

endmodule

// ===== rtl/ott_checker.sv =====
// Port-level checks of the ordered tile table and their bind.
`timescale 1ns / 1ps

module ott_checker
    import ott_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // one word at a time: busy right after an accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken again right after an accept");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[3:0] <= ST_READ_PAST)
        else $error("status code out of range");

    // entry fields are zero unless a read succeeded
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[3:0] != ST_READ_OK)
            |-> (m_axis_tdata[47:13] == '0))
        else $error("entry fields set on a non-read result");

endmodule

bind ordered_tile_table ott_checker u_ott_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
